// ===== hw/rtl/wssr_pkg.sv =====
// shared types and constants for the wheel speed step regulator
// no dependencies; imported by every module of the block
`timescale 1ns / 1ps

package wssr_pkg;

	localparam int PERIOD_W = 16;
	localparam int SUM_W    = 22;
	localparam int CNT_W    = 6;
	localparam int DUTY_W   = 14;
	localparam int RPM_W    = 16;
	localparam int TGT_W    = 8;
	localparam int TOL_W    = 6;
	localparam int CFG_IDX_W = 2;
	localparam int CFG_DAT_W = 8;

	localparam logic [SUM_W-1:0]  RATE_NUMERATOR = 22'd2000000;
	localparam logic [RPM_W-1:0]  RPM_MAX        = 16'hFFFF;
	localparam logic [DUTY_W-1:0] DUTY_STEP      = 14'd100;
	localparam logic [DUTY_W-1:0] DUTY_CEILING   = 14'd14898;
	localparam logic [DUTY_W-1:0] DUTY_RESET     = 14'd3750;
	localparam logic [TGT_W-1:0]  TARGET_RESET   = 8'd50;
	localparam logic [TOL_W-1:0]  TOL_RESET      = 6'd3;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_TARGET_LEFT  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_TARGET_RIGHT = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_TOLERANCE    = 2'd2;

	typedef struct packed {
		logic [PERIOD_W-1:0] period_left;
		logic [PERIOD_W-1:0] period_right;
	} sample_t;

	typedef struct packed {
		logic [DUTY_W-1:0] duty_left;
		logic [DUTY_W-1:0] duty_right;
		logic [RPM_W-1:0]  rpm_left;
		logic [RPM_W-1:0]  rpm_right;
		logic              zero_average;
	} result_t;

	typedef struct packed {
		logic [SUM_W-1:0] sum_left;
		logic [SUM_W-1:0] sum_right;
	} sums_t;

	typedef struct packed {
		logic  empty;
		sums_t data;
	} queue_rd_t;

	typedef struct packed {
		logic [TGT_W-1:0] target_left;
		logic [TGT_W-1:0] target_right;
		logic [TOL_W-1:0] tolerance;
	} cfg_t;

	typedef struct packed {
		logic              start;
		logic [SUM_W-1:0]  dividend;
		logic [RPM_W-1:0]  divisor;
	} div_req_t;

	typedef struct packed {
		logic             done;
		logic [SUM_W-1:0] quotient;
	} div_rsp_t;

endpackage

// ===== hw/rtl/wssr_front.sv =====
// front end: accepts samples and keeps the per-wheel running period sums
// depends on wssr_pkg; hands finished sum pairs to the queue
`timescale 1ns / 1ps

module wssr_front #(
	parameter int SAMPLES_PER_UPDATE = 10
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             accept,
	input  wssr_pkg::sample_t sample,
	output logic             q_push,
	output wssr_pkg::sums_t  q_data
);
	import wssr_pkg::*;

	localparam int N_W = CNT_W + 1;
	localparam logic [N_W-1:0] N_SAMPLES = N_W'(SAMPLES_PER_UPDATE);

	logic [CNT_W-1:0] count_q;
	logic [SUM_W-1:0] sum_l_q;
	logic [SUM_W-1:0] sum_r_q;
	logic [SUM_W-1:0] sum_l_nxt;
	logic [SUM_W-1:0] sum_r_nxt;
	logic             last;

	assign sum_l_nxt = sum_l_q + SUM_W'(sample.period_left);
	assign sum_r_nxt = sum_r_q + SUM_W'(sample.period_right);
	assign last      = !(({1'b0, count_q} + N_W'(1)) < N_SAMPLES);

	assign q_push = accept && last;
	assign q_data = '{sum_left: sum_l_nxt, sum_right: sum_r_nxt};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			sum_l_q <= '0;
			sum_r_q <= '0;
		end else if (accept) begin
			if (last) begin
				count_q <= '0;
				sum_l_q <= '0;
				sum_r_q <= '0;
			end else begin
				count_q <= count_q + CNT_W'(1);
				sum_l_q <= sum_l_nxt;
				sum_r_q <= sum_r_nxt;
			end
		end
	end

endmodule

// ===== hw/rtl/wssr_queue.sv =====
// two-entry queue of sum pairs between front and back
// depends on wssr_pkg
`timescale 1ns / 1ps

module wssr_queue (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	input  wssr_pkg::sums_t     wdata,
	output logic                full,
	input  logic                pop,
	output wssr_pkg::queue_rd_t rd
);
	import wssr_pkg::*;

	sums_t      entry_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] fill_q;
	logic       do_push;
	logic       do_pop;

	assign full     = (fill_q == 2'd2);
	assign rd.empty = (fill_q == 2'd0);
	assign rd.data  = entry_q[rd_ptr_q];
	assign do_push  = push && !full;
	assign do_pop   = pop && !rd.empty;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			fill_q   <= 2'd0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (do_pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			if (do_push && !do_pop) begin
				fill_q <= fill_q + 2'd1;
			end else if (do_pop && !do_push) begin
				fill_q <= fill_q - 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			entry_q[wr_ptr_q] <= wdata;
		end
	end

endmodule

// ===== hw/rtl/wssr_div.sv =====
// shared restoring divider, one quotient bit per cycle
// depends on wssr_pkg; divisor must be nonzero
`timescale 1ns / 1ps

module wssr_div (
	input  logic               clk,
	input  logic               arst_n,
	input  wssr_pkg::div_req_t req,
	output wssr_pkg::div_rsp_t rsp
);
	import wssr_pkg::*;

	localparam int STEP_W = $clog2(SUM_W);

	logic [RPM_W:0]    rem_q;
	logic [SUM_W-1:0]  dvd_q;
	logic [RPM_W-1:0]  dsr_q;
	logic [STEP_W-1:0] step_q;
	logic              busy_q;
	logic              done_q;
	logic [RPM_W:0]    rem_sh;
	logic [RPM_W+1:0]  diff;

	assign rem_sh = {rem_q[RPM_W-1:0], dvd_q[SUM_W-1]};
	assign diff   = {1'b0, rem_sh} - {2'b0, dsr_q};

	assign rsp.done     = done_q;
	assign rsp.quotient = dvd_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
			rem_q  <= '0;
			dvd_q  <= '0;
			dsr_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				step_q <= STEP_W'(SUM_W - 1);
				rem_q  <= '0;
				dvd_q  <= req.dividend;
				dsr_q  <= req.divisor;
			end else if (busy_q) begin
				if (!diff[RPM_W+1]) begin
					rem_q <= diff[RPM_W:0];
				end else begin
					rem_q <= rem_sh;
				end
				dvd_q <= {dvd_q[SUM_W-2:0], !diff[RPM_W+1]};
				if (step_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end else begin
					step_q <= step_q - STEP_W'(1);
				end
			end
		end
	end

endmodule

// ===== hw/rtl/wssr_back.sv =====
// back end: averages, speed division, deadband duty step and result register
// depends on wssr_pkg and drives the shared divider wssr_div
`timescale 1ns / 1ps

module wssr_back #(
	parameter int SAMPLES_PER_UPDATE = 10
) (
	input  logic                clk,
	input  logic                arst_n,
	input  wssr_pkg::queue_rd_t q_rd,
	output logic                q_pop,
	input  wssr_pkg::cfg_t      cfg,
	output wssr_pkg::div_req_t  div_req,
	input  wssr_pkg::div_rsp_t  div_rsp,
	output logic                empty,
	input  logic                pop,
	output wssr_pkg::result_t   result
);
	import wssr_pkg::*;

	// floor divide by the sample count through a rounded-up reciprocal,
	// exact over the whole sum range
	localparam int AVG_SHIFT = SUM_W + $clog2(SAMPLES_PER_UPDATE);
	localparam int RECIP_W   = SUM_W + 1;
	localparam int PROD_W    = SUM_W + RECIP_W;
	localparam logic [RECIP_W-1:0] AVG_RECIP = RECIP_W'(((64'd1 << AVG_SHIFT)
		+ 64'(SAMPLES_PER_UPDATE) - 64'd1) / 64'(SAMPLES_PER_UPDATE));

	typedef enum logic [3:0] {
		S_IDLE,
		S_AVG_L,
		S_AVG_R,
		S_RPM_L_GO,
		S_RPM_L,
		S_RPM_R_GO,
		S_RPM_R,
		S_REG
	} state_t;

	state_t            state_q;
	logic              div_start_q;
	logic [SUM_W-1:0]  dividend_q;
	logic [RPM_W-1:0]  divisor_q;
	logic [SUM_W-1:0]  sum_r_q;
	logic [RPM_W-1:0]  avg_l_q;
	logic [RPM_W-1:0]  avg_r_q;
	logic [RPM_W-1:0]  rpm_l_q;
	logic [RPM_W-1:0]  rpm_r_q;
	logic              zero_q;
	logic [DUTY_W-1:0] duty_l_q;
	logic [DUTY_W-1:0] duty_r_q;
	logic              out_valid_q;
	result_t           result_q;
	logic [RPM_W-1:0]  quot_sat;
	logic [DUTY_W-1:0] duty_l_nxt;
	logic [DUTY_W-1:0] duty_r_nxt;
	logic              out_free;
	logic [SUM_W-1:0]  avg_sum;
	logic [PROD_W-1:0] avg_prod;
	logic [RPM_W-1:0]  avg_quot;

	function automatic logic [DUTY_W-1:0] regulate(
		input logic [DUTY_W-1:0] duty,
		input logic [RPM_W-1:0]  rpm,
		input logic [TGT_W-1:0]  target,
		input logic [TOL_W-1:0]  tol
	);
		logic [RPM_W:0] hi;
		logic [RPM_W:0] rpm_plus_tol;
		logic [DUTY_W-1:0] res;
		hi           = (RPM_W+1)'(target) + (RPM_W+1)'(tol);
		rpm_plus_tol = {1'b0, rpm} + (RPM_W+1)'(tol);
		res          = duty;
		// the second test, rpm < target - tol, is rewritten without a signed difference
		if (({1'b0, rpm} > hi) && (duty > DUTY_STEP)) begin
			res = duty - DUTY_STEP;
		end else if ((rpm_plus_tol < (RPM_W+1)'(target)) && (duty < DUTY_CEILING)) begin
			res = duty + DUTY_STEP;
		end
		return res;
	endfunction

	assign avg_sum  = (state_q == S_AVG_L) ? dividend_q : sum_r_q;
	assign avg_prod = PROD_W'(avg_sum) * PROD_W'(AVG_RECIP);
	assign avg_quot = avg_prod[AVG_SHIFT +: RPM_W];

	assign quot_sat   = (div_rsp.quotient[SUM_W-1:RPM_W] != '0) ? RPM_MAX
		: div_rsp.quotient[RPM_W-1:0];
	assign duty_l_nxt = regulate(duty_l_q, rpm_l_q, cfg.target_left, cfg.tolerance);
	assign duty_r_nxt = regulate(duty_r_q, rpm_r_q, cfg.target_right, cfg.tolerance);
	assign out_free   = !out_valid_q || pop;

	assign q_pop   = (state_q == S_IDLE) && !q_rd.empty;
	assign div_req = '{start: div_start_q, dividend: dividend_q, divisor: divisor_q};
	assign empty   = !out_valid_q;
	assign result  = result_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			div_start_q <= 1'b0;
			dividend_q  <= '0;
			divisor_q   <= '0;
			sum_r_q     <= '0;
			avg_l_q     <= '0;
			avg_r_q     <= '0;
			rpm_l_q     <= '0;
			rpm_r_q     <= '0;
			zero_q      <= 1'b0;
			duty_l_q    <= DUTY_RESET;
			duty_r_q    <= DUTY_RESET;
			out_valid_q <= 1'b0;
			result_q    <= '0;
		end else begin
			div_start_q <= 1'b0;
			if (pop && out_valid_q) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (!q_rd.empty) begin
						sum_r_q    <= q_rd.data.sum_right;
						dividend_q <= q_rd.data.sum_left;
						zero_q     <= 1'b0;
						state_q    <= S_AVG_L;
					end
				end
				S_AVG_L: begin
					avg_l_q <= avg_quot;
					state_q <= S_AVG_R;
				end
				S_AVG_R: begin
					avg_r_q <= avg_quot;
					state_q <= S_RPM_L_GO;
				end
				S_RPM_L_GO: begin
					if (avg_l_q == '0) begin
						rpm_l_q <= RPM_MAX;
						zero_q  <= 1'b1;
						state_q <= S_RPM_R_GO;
					end else begin
						dividend_q  <= RATE_NUMERATOR;
						divisor_q   <= avg_l_q;
						div_start_q <= 1'b1;
						state_q     <= S_RPM_L;
					end
				end
				S_RPM_L: begin
					if (div_rsp.done) begin
						rpm_l_q <= quot_sat;
						state_q <= S_RPM_R_GO;
					end
				end
				S_RPM_R_GO: begin
					if (avg_r_q == '0) begin
						rpm_r_q <= RPM_MAX;
						zero_q  <= 1'b1;
						state_q <= S_REG;
					end else begin
						dividend_q  <= RATE_NUMERATOR;
						divisor_q   <= avg_r_q;
						div_start_q <= 1'b1;
						state_q     <= S_RPM_R;
					end
				end
				S_RPM_R: begin
					if (div_rsp.done) begin
						rpm_r_q <= quot_sat;
						state_q <= S_REG;
					end
				end
				S_REG: begin
					// wait for the result register to drain
					if (out_free) begin
						duty_l_q    <= duty_l_nxt;
						duty_r_q    <= duty_r_nxt;
						result_q    <= '{duty_left: duty_l_nxt, duty_right: duty_r_nxt,
							rpm_left: rpm_l_q, rpm_right: rpm_r_q, zero_average: zero_q};
						out_valid_q <= 1'b1;
						state_q     <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule

// ===== hw/rtl/wheel_speed_step_regulator.sv =====
// wheel speed step regulator: items are taken one per cycle while full is low;
// every SAMPLES_PER_UPDATE-th item queues a sum pair for the back end
// before empty falls, an update can wait behind an earlier update or for the result
// register to drain; a zero average skips that wheel's speed division
// back end runs at most two 22-step speed divisions per update on the shared
// divider; full rises when two sum pairs wait. reset (arst_n low, asynchronous)
// clears sums and queue, restores duties to 3750 and the config registers
`timescale 1ns / 1ps

module wheel_speed_step_regulator #(
	parameter int SAMPLES_PER_UPDATE = 10
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 push,
	output logic                                 full,
	input  wssr_pkg::sample_t                    sample,
	output logic                                 empty,
	input  logic                                 pop,
	output wssr_pkg::result_t                    result,
	input  logic                                 cfg_we,
	input  logic [wssr_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [wssr_pkg::CFG_DAT_W-1:0]       cfg_wdata
);
	import wssr_pkg::*;

	cfg_t      cfg_q;
	logic      accept;
	logic      q_push;
	sums_t     q_wdata;
	logic      q_pop;
	queue_rd_t q_rd;
	div_req_t  div_req;
	div_rsp_t  div_rsp;

	assign accept = push && !full;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '{target_left: TARGET_RESET, target_right: TARGET_RESET,
				tolerance: TOL_RESET};
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_TARGET_LEFT:  cfg_q.target_left  <= cfg_wdata;
				REG_TARGET_RIGHT: cfg_q.target_right <= cfg_wdata;
				REG_TOLERANCE:    cfg_q.tolerance    <= cfg_wdata[TOL_W-1:0];
				default: begin
				end
			endcase
		end
	end

	wssr_front #(
		.SAMPLES_PER_UPDATE(SAMPLES_PER_UPDATE)
	) u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.accept (accept),
		.sample (sample),
		.q_push (q_push),
		.q_data (q_wdata)
	);

	wssr_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (q_push),
		.wdata  (q_wdata),
		.full   (full),
		.pop    (q_pop),
		.rd     (q_rd)
	);

	wssr_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	wssr_back #(
		.SAMPLES_PER_UPDATE(SAMPLES_PER_UPDATE)
	) u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.q_rd    (q_rd),
		.q_pop   (q_pop),
		.cfg     (cfg_q),
		.div_req (div_req),
		.div_rsp (div_rsp),
		.empty   (empty),
		.pop     (pop),
		.result  (result)
	);

endmodule

// ===== hw/rtl/wssr_checker.sv =====
// port-level checks for the wheel speed step regulator, bound to the top level
// depends on wssr_pkg and wheel_speed_step_regulator
`timescale 1ns / 1ps

module wssr_checker (
	input logic              clk,
	input logic              arst_n,
	input logic              empty,
	input logic              pop,
	input wssr_pkg::result_t result
);
	import wssr_pkg::*;

	// a waiting item is held until taken
	assert property (@(posedge clk) disable iff (!arst_n)
		!empty && !pop |=> !empty)
		else $error("result withdrawn before pop");

	assert property (@(posedge clk) disable iff (!arst_n)
		!empty && !pop |=> $stable(result))
		else $error("waiting result changed");

	// duty never leaves the stepping range
	assert property (@(posedge clk) disable iff (!arst_n)
		!empty |-> (result.duty_left <= 14'd14997) && (result.duty_right <= 14'd14997)
			&& (result.duty_left != '0) && (result.duty_right != '0))
		else $error("duty out of range");

	// a zero average always shows as a saturated speed
	assert property (@(posedge clk) disable iff (!arst_n)
		!empty && result.zero_average |-> (result.rpm_left == RPM_MAX)
			|| (result.rpm_right == RPM_MAX))
		else $error("zero average without saturated rpm");

endmodule

bind wheel_speed_step_regulator wssr_checker u_wssr_checker (.*);
